FILE: rtl/stl_pkg.sv
// Shared types, character codes and keyword tables for the source text lexer.
// Used by stl_classify and source_text_style_lexer_top; depends on nothing.
package stl_pkg;

    localparam int COMMENT_DEPTH = 8;
    localparam int LOOKAHEAD     = 23;

    localparam int FILL_W       = $clog2(LOOKAHEAD + 1);
    localparam int IDX_W        = $clog2(LOOKAHEAD);
    localparam int CLS_RAW_W    = $clog2(6 + COMMENT_DEPTH);
    localparam int CLS_W        = (CLS_RAW_W > 4) ? CLS_RAW_W : 4;
    localparam int BYTE_CLASS_W = 4;
    localparam int HEAD_W       = 3;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 1;

    typedef logic [7:0]                  t_byte;
    typedef logic [LOOKAHEAD-1:0][7:0]   t_win;
    typedef logic [CLS_W-1:0]            t_class;
    typedef logic [HEAD_W-1:0]           t_head;

    // class codes
    localparam t_class CLS_TEXT         = t_class'(0);
    localparam t_class CLS_STRING       = t_class'(1);
    localparam t_class CLS_SUBST        = t_class'(2);
    localparam t_class CLS_CODE         = t_class'(3);
    localparam t_class CLS_HEADING      = t_class'(4);
    localparam t_class CLS_COMMENT0     = t_class'(5);
    localparam t_class CLS_COMMENT_LAST = t_class'(4 + COMMENT_DEPTH);
    localparam t_class CLS_LIMIT        = t_class'(5 + COMMENT_DEPTH);

    localparam t_head HEAD_NONE = 3'd0;
    localparam t_head HEAD_DOC  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_STYLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENSION_MODE = 1'b1;

    // character codes
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_SP     = 8'h20;
    localparam t_byte CH_BANG   = 8'h21;
    localparam t_byte CH_DQUOTE = 8'h22;
    localparam t_byte CH_LPAR   = 8'h28;
    localparam t_byte CH_RPAR   = 8'h29;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_MINUS  = 8'h2D;
    localparam t_byte CH_DOT    = 8'h2E;
    localparam t_byte CH_COLON  = 8'h3A;
    localparam t_byte CH_SEMI   = 8'h3B;
    localparam t_byte CH_QUEST  = 8'h3F;
    localparam t_byte CH_LBRACK = 8'h5B;
    localparam t_byte CH_RBRACK = 8'h5D;
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte UTF_LEAD  = 8'hE2;
    localparam t_byte UTF_MID   = 8'h80;
    localparam t_byte UTF_LQUOT = 8'h9C;
    localparam t_byte UTF_RQUOT = 8'h9D;

    // heading keywords, lower case, padded to KW_MAX
    localparam int KW_NUM = 6;
    localparam int KW_MAX = 7;
    localparam t_byte KW_CHARS [KW_NUM][KW_MAX] = '{
        '{"v", "o", "l", "u", "m", "e", 8'h00},
        '{"b", "o", "o", "k", 8'h00, 8'h00, 8'h00},
        '{"p", "a", "r", "t", 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "p", "t", "e", "r"},
        '{"s", "e", "c", "t", "i", "o", "n"},
        '{"e", "x", "a", "m", "p", "l", "e"}
    };
    localparam int KW_LEN [KW_NUM] = '{6, 4, 4, 7, 7, 7};

    localparam int DOC_LEN  = 23;
    localparam logic [DOC_LEN*8-1:0] DOC_TEXT = "---- documentation ----";
    localparam bit DOC_FITS = (DOC_LEN <= LOOKAHEAD);
    localparam int DOC_CMP  = DOC_FITS ? DOC_LEN : LOOKAHEAD;

    typedef struct packed {
        t_class     cls;
        t_byte      prev;
        logic       lstart;
        logic [1:0] skip;
    } t_lex_state;

    typedef struct packed {
        t_lex_state nxt;
        t_class     cls_out;
        t_head      head;
    } t_emit;

    function automatic t_byte to_lower(input t_byte b);
        return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
    endfunction

    function automatic t_byte doc_char(input int i);
        return DOC_TEXT[(DOC_LEN-1-i)*8 +: 8];
    endfunction

    function automatic logic quote_ok(input t_byte p);
        return p inside {8'h00, CH_SP, CH_TAB, CH_CR, CH_LF, CH_DOT, CH_COMMA, CH_COLON,
                         CH_SEMI, CH_QUEST, CH_BANG, CH_LPAR, CH_RPAR, CH_LBRACE,
                         CH_RBRACE, CH_LBRACK, CH_RBRACK};
    endfunction

    // out-of-range start styles fall back to text
    function automatic t_class start_class(input logic [CFG_W-1:0] s);
        return (t_class'(s) >= CLS_LIMIT) ? CLS_TEXT : t_class'(s);
    endfunction

endpackage

FILE: rtl/stl_classify.sv
// Classifies the oldest byte of the lookahead window and computes the next lexer state.
// Pure combinational; uses stl_pkg.
module stl_classify (
    input  stl_pkg::t_win               i_win,
    input  logic [stl_pkg::FILL_W-1:0]  i_fill,
    input  logic                        i_ext,
    input  stl_pkg::t_lex_state         i_st,
    output stl_pkg::t_emit              o_res
);
    import stl_pkg::*;

    logic [LOOKAHEAD-1:0] pv;
    t_win                 lw;
    logic [KW_NUM-1:0]    kw_hit;
    logic                 doc_hit;
    logic                 curly;
    logic                 alpha;
    t_head                level;
    t_byte                b;

    assign b = i_win[0];

    always_comb begin
        for (int i = 0; i < LOOKAHEAD; i++) begin
            pv[i] = (i_fill > FILL_W'(i));
            lw[i] = to_lower(i_win[i]);
        end
    end

    // keyword and marker compares, all against fixed window positions
    always_comb begin
        for (int k = 0; k < KW_NUM; k++) begin
            kw_hit[k] = pv[KW_LEN[k]] &&
                        ((i_win[KW_LEN[k]] == CH_SP) || (i_win[KW_LEN[k]] == CH_TAB) ||
                         (i_ext && (i_win[KW_LEN[k]] == CH_COLON)));
            for (int i = 0; i < KW_MAX; i++) begin
                if (i < KW_LEN[k]) begin
                    kw_hit[k] = kw_hit[k] && pv[i] && (lw[i] == KW_CHARS[k][i]);
                end
            end
        end
        doc_hit = i_ext && DOC_FITS;
        for (int i = 0; i < DOC_CMP; i++) begin
            doc_hit = doc_hit && pv[i] && (lw[i] == doc_char(i));
        end
    end

    always_comb begin
        level = HEAD_NONE;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                level = HEAD_W'(k + 1);
            end
        end
        if (doc_hit) begin
            level = HEAD_DOC;
        end
    end

    assign curly = pv[2] && (i_win[0] == UTF_LEAD) && (i_win[1] == UTF_MID) &&
                   ((i_win[2] == UTF_LQUOT) || (i_win[2] == UTF_RQUOT));
    assign alpha = (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});

    always_comb begin
        o_res.nxt      = i_st;
        o_res.nxt.prev = b;
        o_res.cls_out  = i_st.cls;
        o_res.head     = HEAD_NONE;
        if (i_st.skip != 2'd0) begin
            // tail bytes of a closing curly quote
            o_res.nxt.skip = i_st.skip - 2'd1;
            if (i_st.skip == 2'd1) begin
                o_res.nxt.cls = CLS_TEXT;
            end
        end else begin
            o_res.nxt.lstart = (b == CH_CR) || (b == CH_LF);
            if (i_st.cls == CLS_STRING || i_st.cls == CLS_SUBST) begin
                if (b == CH_DQUOTE) begin
                    o_res.nxt.cls = CLS_TEXT;
                end else if (curly) begin
                    o_res.nxt.skip = 2'd2;
                end else if (i_st.cls == CLS_STRING && b == CH_LBRACK) begin
                    o_res.cls_out = CLS_SUBST;
                    o_res.nxt.cls = CLS_SUBST;
                end else if (i_st.cls == CLS_SUBST && b == CH_RBRACK) begin
                    o_res.nxt.cls = CLS_STRING;
                end
            end else if (i_st.cls == CLS_CODE) begin
                if (b == CH_RPAR && i_st.prev == CH_MINUS) begin
                    o_res.nxt.cls = CLS_TEXT;
                end
            end else if (i_st.cls == CLS_HEADING) begin
                if (b == CH_CR || b == CH_LF) begin
                    o_res.cls_out = CLS_TEXT;
                    o_res.nxt.cls = CLS_TEXT;
                end
            end else if (i_st.cls inside {[CLS_COMMENT0:CLS_COMMENT_LAST]}) begin
                if (b == CH_LBRACK) begin
                    // deepest level ignores a further opening bracket
                    if (i_st.cls != CLS_COMMENT_LAST) begin
                        o_res.cls_out = i_st.cls + t_class'(1);
                        o_res.nxt.cls = i_st.cls + t_class'(1);
                    end
                end else if (b == CH_RBRACK) begin
                    o_res.nxt.cls = (i_st.cls == CLS_COMMENT0) ? CLS_TEXT
                                                               : i_st.cls - t_class'(1);
                end
            end else begin
                if (i_st.lstart && (alpha || b == CH_MINUS) && level != HEAD_NONE) begin
                    o_res.cls_out = CLS_HEADING;
                    o_res.nxt.cls = CLS_HEADING;
                    o_res.head    = level;
                end else if (b == CH_LBRACK) begin
                    o_res.cls_out = CLS_COMMENT0;
                    o_res.nxt.cls = CLS_COMMENT0;
                end else if (b == CH_LPAR && pv[1] && i_win[1] == CH_MINUS) begin
                    o_res.cls_out = CLS_CODE;
                    o_res.nxt.cls = CLS_CODE;
                end else if ((b == CH_DQUOTE || curly) && quote_ok(i_st.prev)) begin
                    o_res.cls_out = CLS_STRING;
                    o_res.nxt.cls = CLS_STRING;
                end else begin
                    o_res.cls_out = CLS_TEXT;
                    o_res.nxt.cls = CLS_TEXT;
                end
            end
        end
    end

endmodule

FILE: rtl/source_text_style_lexer_top.sv
// Top level of the source text lexer: lookahead window, lexer state, result register.
// Depends on stl_pkg and stl_classify.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_text_byte, i_last_byte
//  result    out        o_valid / i_stall   o_out_byte, o_byte_class, o_heading_start,
//                                           o_final_result
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data (no read-back)
//
// Unstalled steady state: one word in, one out per cycle. A byte is classified once
// LOOKAHEAD bytes (itself included) are pending, so the first result of a stream
// appears after the window fills. A word with i_last_byte set starts a flush that
// drains up to LOOKAHEAD results, one per unstalled cycle, with o_stall held.
// Synchronous active-low reset clears control state; window contents are not reset.
// A stall on the result side backs up into o_stall only once the window is full.
module source_text_style_lexer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_text_byte,
    input  logic                               i_last_byte,
    // result words
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [7:0]                         o_out_byte,
    output logic [stl_pkg::BYTE_CLASS_W-1:0]   o_byte_class,
    output logic [stl_pkg::HEAD_W-1:0]         o_heading_start,
    output logic                               o_final_result,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stl_pkg::CFG_W-1:0]          i_cfg_data
);
    import stl_pkg::*;

    // configuration
    logic [CFG_W-1:0]  r_start_style;
    logic              r_ext;

    // lookahead window: r_win[0] is the oldest pending byte
    t_win              r_win, n_win;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_flush, n_flush;
    logic              r_started, n_started;
    t_lex_state        r_st, n_st;

    // result register
    logic              r_ovalid, n_ovalid;
    t_byte             r_obyte;
    logic [BYTE_CLASS_W-1:0] r_oclass;
    t_head             r_ohead;
    logic              r_ofinal;

    logic              w_accept;
    logic              w_have;
    logic              w_emit;
    logic              w_final;
    logic [FILL_W-1:0] w_wpos;
    t_emit             w_res;

    stl_classify u_classify (
        .i_win  (r_win),
        .i_fill (r_fill),
        .i_ext  (r_ext),
        .i_st   (r_st),
        .o_res  (w_res)
    );

    // a result is due when the window is full, or anything is pending in a flush
    assign w_have   = (r_fill == FILL_W'(LOOKAHEAD)) || (r_flush && (r_fill != '0));
    assign w_emit   = w_have && (!r_ovalid || !i_stall);
    assign w_final  = r_flush && (r_fill == FILL_W'(1));
    assign o_stall  = r_flush || ((r_fill == FILL_W'(LOOKAHEAD)) && !w_emit);
    assign w_accept = i_valid && !o_stall;
    // new byte lands after the shift
    assign w_wpos   = r_fill - FILL_W'(w_emit);

    always_comb begin
        // oldest byte leaves from slot 0
        n_win = w_emit ? (r_win >> 8) : r_win;
        for (int i = 0; i < LOOKAHEAD; i++) begin
            if (w_accept && (w_wpos == FILL_W'(i))) begin
                n_win[i] = i_text_byte;
            end
        end
    end

    always_comb begin
        n_fill    = r_fill - FILL_W'(w_emit) + FILL_W'(w_accept);
        n_flush   = r_flush;
        n_started = r_started;
        n_st      = r_st;
        n_ovalid  = r_ovalid && i_stall;
        if (w_accept) begin
            n_started = 1'b1;
            if (i_last_byte) begin
                n_flush = 1'b1;
            end
        end
        if (w_emit) begin
            n_ovalid = 1'b1;
            if (w_final) begin
                // stream done: back to reset state, registers kept
                n_flush       = 1'b0;
                n_started     = 1'b0;
                n_st.cls      = start_class(r_start_style);
                n_st.prev     = '0;
                n_st.lstart   = 1'b1;
                n_st.skip     = 2'd0;
            end else begin
                n_st = w_res.nxt;
            end
        end else if (!r_started) begin
            // track start_style until the stream's first byte
            n_st.cls = start_class(r_start_style);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_style <= '0;
            r_ext         <= 1'b0;
            r_fill        <= '0;
            r_flush       <= 1'b0;
            r_started     <= 1'b0;
            r_st.cls      <= CLS_TEXT;
            r_st.prev     <= '0;
            r_st.lstart   <= 1'b1;
            r_st.skip     <= 2'd0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_STYLE:    r_start_style <= i_cfg_data;
                    CFG_EXTENSION_MODE: r_ext         <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_fill    <= n_fill;
            r_flush   <= n_flush;
            r_started <= n_started;
            r_st      <= n_st;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (w_emit) begin
            r_obyte  <= r_win[0];
            r_oclass <= w_res.cls_out[BYTE_CLASS_W-1:0];
            r_ohead  <= w_res.head;
            r_ofinal <= w_final;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_out_byte      = r_obyte;
    assign o_byte_class    = r_oclass;
    assign o_heading_start = r_ohead;
    assign o_final_result  = r_ofinal;

    // window never overfills
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LOOKAHEAD))
        else $error("lookahead window overfilled");

    // the final result empties the window and ends the flush
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_final) |=> ((r_fill == '0) && !r_flush && !r_started))
        else $error("flush did not end cleanly");

    // curly-quote tail bytes only occur while closing a string or substitution
    a_skip_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.skip != 2'd0) |-> ((r_st.cls == CLS_STRING) || (r_st.cls == CLS_SUBST)))
        else $error("quote skip outside string");

    // a heading start is always reported with the heading class
    a_head_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_heading_start != HEAD_NONE)) |->
            (o_byte_class == CLS_HEADING[BYTE_CLASS_W-1:0]))
        else $error("heading start without heading class");

endmodule

FILE: dv/stl_checker.sv
// Scoreboard for the source text lexer: watches the input, result and register
// ports, predicts the class of every byte and compares results in order.
// Depends on stl_pkg.
module stl_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [7:0]                       i_text_byte,
    input  logic                             i_last_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [7:0]                       i_out_byte,
    input  logic [stl_pkg::BYTE_CLASS_W-1:0] i_byte_class,
    input  logic [stl_pkg::HEAD_W-1:0]       i_heading_start,
    input  logic                             i_final_result,
    input  logic                             i_cfg_we,
    input  logic [stl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stl_pkg::CFG_W-1:0]        i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import stl_pkg::*;

    localparam t_byte NO_BYTE = 8'h00;

    typedef struct packed {
        t_byte                   text;
        logic [BYTE_CLASS_W-1:0] cls;
        t_head                   head;
        logic                    fin;
    } t_styled_byte;

    string key_words [6] = '{"volume", "book", "part", "chapter", "section", "example"};
    string doc_marker    = "---- documentation ----";

    t_styled_byte     expected_styles [$];
    t_byte            pend_bytes [LOOKAHEAD];
    int               pend_count;
    t_class           style_now;
    t_byte            prior_byte;
    logic             line_begin;
    int               quote_tail;     // closing curly quote bytes still to pass
    logic             stream_open;
    logic [CFG_W-1:0] style_reg;
    logic             ext_mode;
    int               fail_total = 0;

    // pending byte i, or -1 past the end of the stream
    function automatic int look(input int i);
        if (i >= pend_count || i >= LOOKAHEAD)
            return -1;
        return int'(pend_bytes[i]);
    endfunction

    function automatic logic curly_at(input int i);
        int c;
        c = look(i + 2);
        return look(i) == int'(UTF_LEAD) && look(i + 1) == int'(UTF_MID)
            && (c == int'(UTF_LQUOT) || c == int'(UTF_RQUOT));
    endfunction

    function automatic logic word_here(input string w);
        int c;
        for (int k = 0; k < w.len(); k++) begin
            c = look(k);
            if (c >= int'("A") && c <= int'("Z"))
                c += 32;
            if (c != int'(w[k]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_head heading_of();
        int f;
        if (ext_mode && word_here(doc_marker))
            return HEAD_DOC;
        for (int k = 0; k < 6; k++) begin
            if (word_here(key_words[k])) begin
                f = look(key_words[k].len());
                if (f == int'(CH_SP) || f == int'(CH_TAB) || (ext_mode && f == int'(CH_COLON)))
                    return t_head'(k + 1);
            end
        end
        return HEAD_NONE;
    endfunction

    function automatic logic quote_opens(input t_byte p);
        return p inside {NO_BYTE, CH_SP, CH_TAB, CH_CR, CH_LF, CH_DOT, CH_COMMA, CH_COLON,
                         CH_SEMI, CH_QUEST, CH_BANG, CH_LPAR, CH_RPAR, CH_LBRACE,
                         CH_RBRACE, CH_LBRACK, CH_RBRACK};
    endfunction

    function automatic t_class start_of(input logic [CFG_W-1:0] s);
        return (t_class'(s) >= CLS_LIMIT) ? CLS_TEXT : t_class'(s);
    endfunction

    task automatic restart_stream();
        foreach (pend_bytes[k])
            pend_bytes[k] = '0;
        pend_count  = 0;
        style_now   = start_of(style_reg);
        prior_byte  = NO_BYTE;
        line_begin  = 1'b1;
        quote_tail  = 0;
        stream_open = 1'b0;
    endtask

    task automatic classify_oldest(output t_styled_byte r);
        t_byte  b;
        t_class cls;
        t_class nxt;
        t_head  head;
        logic   alpha;
        b    = pend_bytes[0];
        cls  = style_now;
        nxt  = style_now;
        head = HEAD_NONE;
        if (quote_tail > 0) begin
            quote_tail--;
            if (quote_tail == 0)
                nxt = CLS_TEXT;
        end else begin
            case (style_now)
                CLS_STRING: begin
                    if (b == CH_DQUOTE) nxt = CLS_TEXT;
                    else if (curly_at(0)) quote_tail = 2;
                    else if (b == CH_LBRACK) begin
                        cls = CLS_SUBST;
                        nxt = CLS_SUBST;
                    end
                end
                CLS_SUBST: begin
                    if (b == CH_DQUOTE) nxt = CLS_TEXT;
                    else if (curly_at(0)) quote_tail = 2;
                    else if (b == CH_RBRACK) nxt = CLS_STRING;
                end
                CLS_CODE: begin
                    if (b == CH_RPAR && prior_byte == CH_MINUS)
                        nxt = CLS_TEXT;
                end
                CLS_HEADING: begin
                    if (b == CH_CR || b == CH_LF) begin
                        cls = CLS_TEXT;
                        nxt = CLS_TEXT;
                    end
                end
                default: begin
                    if (style_now >= CLS_COMMENT0 && style_now <= CLS_COMMENT_LAST) begin
                        // deepest level ignores a further open bracket
                        if (b == CH_LBRACK) begin
                            if (style_now != CLS_COMMENT_LAST) begin
                                cls = style_now + 1'b1;
                                nxt = cls;
                            end
                        end else if (b == CH_RBRACK) begin
                            nxt = (style_now == CLS_COMMENT0) ? CLS_TEXT : style_now - 1'b1;
                        end
                    end else begin
                        alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
                        if (line_begin && (alpha || b == CH_MINUS))
                            head = heading_of();
                        if (head != HEAD_NONE) begin
                            cls = CLS_HEADING;
                            nxt = CLS_HEADING;
                        end else if (b == CH_LBRACK) begin
                            cls = CLS_COMMENT0;
                            nxt = CLS_COMMENT0;
                        end else if (b == CH_LPAR && look(1) == int'(CH_MINUS)) begin
                            cls = CLS_CODE;
                            nxt = CLS_CODE;
                        end else if ((b == CH_DQUOTE || curly_at(0)) && quote_opens(prior_byte))
                        begin
                            cls = CLS_STRING;
                            nxt = CLS_STRING;
                        end else begin
                            cls = CLS_TEXT;
                            nxt = CLS_TEXT;
                        end
                    end
                end
            endcase
            line_begin = (b == CH_CR || b == CH_LF);
        end
        prior_byte = b;
        style_now  = nxt;
        r.text = b;
        r.cls  = cls[BYTE_CLASS_W-1:0];
        r.head = head;
        r.fin  = 1'b0;
        for (int k = 0; k < LOOKAHEAD - 1; k++)
            pend_bytes[k] = pend_bytes[k + 1];
        pend_bytes[LOOKAHEAD - 1] = '0;
        pend_count--;
    endtask

    task automatic predict_word(input t_byte b, input logic last);
        t_styled_byte r;
        if (!stream_open) begin
            style_now   = start_of(style_reg);
            stream_open = 1'b1;
        end
        if (pend_count < LOOKAHEAD) begin
            pend_bytes[pend_count] = b;
            pend_count++;
        end
        if (last) begin
            while (pend_count > 0) begin
                classify_oldest(r);
                r.fin = (pend_count == 0);
                expected_styles.push_back(r);
            end
            restart_stream();
        end else if (pend_count >= LOOKAHEAD) begin
            classify_oldest(r);
            expected_styles.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_styled_byte got;
        t_styled_byte want;
        if (!i_rst_n) begin
            style_reg = '0;
            ext_mode  = 1'b0;
            restart_stream();
            expected_styles.delete();
        end else begin
            // results leave a register, so compare before adding this edge's prediction
            if (i_out_valid && !i_out_stall) begin
                got.text = i_out_byte;
                got.cls  = i_byte_class;
                got.head = i_heading_start;
                got.fin  = i_final_result;
                if (expected_styles.size() == 0) begin
                    fail_total++;
                    $display("%0t: expected no result, got byte=%h class=%0d head=%0d final=%0b",
                             $time, got.text, got.cls, got.head, got.fin);
                end else begin
                    want = expected_styles.pop_front();
                    if (got.text !== want.text || got.cls !== want.cls
                            || got.head !== want.head || got.fin !== want.fin) begin
                        fail_total++;
                        $display("%0t: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                                 $time, want.text, want.cls, want.head, want.fin,
                                 got.text, got.cls, got.head, got.fin);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START_STYLE) begin
                    style_reg = i_cfg_data;
                    if (!stream_open)
                        style_now = start_of(style_reg);
                end else if (i_cfg_index == CFG_EXTENSION_MODE) begin
                    ext_mode = i_cfg_data[0];
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_word(i_text_byte, i_last_byte);
        end
        o_pending    <= expected_styles.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the source text lexer: clock, reset, register writes,
// byte streams and handshake idling. Prediction and comparison live in
// stl_checker; depends on stl_pkg and source_text_style_lexer_top.
module tb_top;
    import stl_pkg::*;

    localparam int RANDOM_BYTES    = 140;
    localparam int PHASE_BYTES     = 30;
    // a flush drains at most LOOKAHEAD words, with margin on top
    localparam int SETTLE_CYCLES   = LOOKAHEAD + 8;
    // quiet stretches in a correct run: settle pause plus register writes, sender gaps,
    // random receiver stalls; taken many times over
    localparam int WATCHDOG_CYCLES = 2000;

    // bytes that may stand before an opening quote
    localparam t_byte QUOTE_LEADS [14] = '{CH_SP, CH_TAB, CH_CR, CH_DOT, CH_COMMA, CH_COLON,
        CH_SEMI, CH_QUEST, CH_BANG, CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_RBRACK};

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    byte_valid = 1'b0;
    logic                    byte_stall;
    t_byte                   text_byte  = '0;
    logic                    last_byte  = 1'b0;
    logic                    res_valid;
    logic                    res_stall  = 1'b0;
    logic [7:0]              res_byte;
    logic [BYTE_CLASS_W-1:0] res_class;
    logic [HEAD_W-1:0]       res_head;
    logic                    res_final;
    logic                    cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = CFG_START_STYLE;
    logic [CFG_W-1:0]        cfg_data   = '0;
    int                      fail_count;
    int                      pending;

    t_byte text_q [$];          // bytes of the stream being built
    int    items_sent    = 0;
    int    streams_sent  = 0;
    int    settings_used = 0;
    int    results_seen  = 0;
    int    quiet_cycles  = 0;
    // sender bursts and receiver stall pattern, retuned every phase
    int    burst_left    = 0;
    int    gap_max       = 0;
    int    stall_pct     = 0;
    int    stall_span    = 0;
    int    stall_hold    = 0;

    always #5 clk = ~clk;

    source_text_style_lexer_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (byte_valid),
        .o_stall         (byte_stall),
        .i_text_byte     (text_byte),
        .i_last_byte     (last_byte),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_out_byte      (res_byte),
        .o_byte_class    (res_class),
        .o_heading_start (res_head),
        .o_final_result  (res_final),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    stl_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (byte_valid),
        .i_in_stall      (byte_stall),
        .i_text_byte     (text_byte),
        .i_last_byte     (last_byte),
        .i_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .i_out_byte      (res_byte),
        .i_byte_class    (res_class),
        .i_heading_start (res_head),
        .i_final_result  (res_final),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver: each stall decision is held for a random number of cycles.
    always @(negedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            res_stall  <= ($urandom_range(0, 99) < stall_pct);
            stall_hold <= $urandom_range(0, stall_span);
        end
    end

    // Watchdog: any accepted word on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (res_valid && !res_stall)
            results_seen <= results_seen + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void push_letters(input int n);
        for (int k = 0; k < n; k++)
            text_q.push_back($urandom_range(0, 1) ? t_byte'($urandom_range(8'h61, 8'h7A))
                                                  : t_byte'($urandom_range(8'h41, 8'h5A)));
    endfunction

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            text_q.push_back(t_byte'(s[k]));
    endfunction

    // straight quote or a UTF-8 curly one (either direction)
    function automatic void push_quote();
        if ($urandom_range(0, 2) == 0) begin
            text_q.push_back(CH_DQUOTE);
        end else begin
            text_q.push_back(UTF_LEAD);
            text_q.push_back(UTF_MID);
            text_q.push_back($urandom_range(0, 1) ? UTF_LQUOT : UTF_RQUOT);
        end
    endfunction

    // One well-formed (or slightly broken) piece of source text.
    task automatic add_fragment();
        int    k;
        int    n;
        t_byte c;
        case ($urandom_range(0, 9))
            0, 1: begin
                // heading keyword, mixed case, usually right after a line break
                if ($urandom_range(0, 3) != 0)
                    text_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
                k = $urandom_range(0, KW_NUM - 1);
                for (int j = 0; j < KW_LEN[k]; j++) begin
                    c = KW_CHARS[k][j];
                    text_q.push_back($urandom_range(0, 2) == 0 ? (c & 8'hDF) : c);
                end
                case ($urandom_range(0, 4))
                    0: text_q.push_back(CH_SP);
                    1: text_q.push_back(CH_TAB);
                    2: text_q.push_back(CH_COLON);
                    3: push_letters(1);
                    default: ;
                endcase
                push_letters($urandom_range(0, 5));
                text_q.push_back(CH_LF);
            end
            2: begin
                // documentation marker, now and then with one byte spoiled
                text_q.push_back(CH_LF);
                k = $urandom_range(0, 3 * DOC_LEN);
                for (int j = 0; j < DOC_LEN; j++)
                    text_q.push_back(j == k ? t_byte'($urandom_range(0, 255))
                                            : DOC_TEXT[(DOC_LEN - 1 - j) * 8 +: 8]);
                push_letters($urandom_range(0, 3));
                text_q.push_back(CH_CR);
            end
            3: begin
                // string with an optional substitution; a letter lead blocks the open
                if ($urandom_range(0, 3) == 0)
                    push_letters(1);
                else
                    text_q.push_back(QUOTE_LEADS[$urandom_range(0, 13)]);
                push_quote();
                push_letters($urandom_range(0, 4));
                if ($urandom_range(0, 1)) begin
                    text_q.push_back(CH_LBRACK);
                    push_letters($urandom_range(0, 3));
                    text_q.push_back(CH_RBRACK);
                end
                push_letters($urandom_range(0, 3));
                push_quote();
            end
            4: begin
                // embedded code, sometimes without its dashes
                text_q.push_back(CH_LPAR);
                if ($urandom_range(0, 3) != 0)
                    text_q.push_back(CH_MINUS);
                push_letters($urandom_range(0, 4));
                if ($urandom_range(0, 3) != 0)
                    text_q.push_back(CH_MINUS);
                text_q.push_back(CH_RPAR);
            end
            5: begin
                // nested comments, sometimes deeper than the block tracks
                n = $urandom_range(1, COMMENT_DEPTH + 2);
                for (int j = 0; j < n; j++) begin
                    text_q.push_back(CH_LBRACK);
                    push_letters($urandom_range(0, 2));
                end
                k = $urandom_range(0, n + 1);
                for (int j = 0; j < k; j++) begin
                    text_q.push_back(CH_RBRACK);
                    push_letters($urandom_range(0, 1));
                end
            end
            6: begin
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++)
                    text_q.push_back(t_byte'($urandom_range(0, 255)));
            end
            7: begin
                // broken curly quote
                text_q.push_back(UTF_LEAD);
                if ($urandom_range(0, 1))
                    text_q.push_back(UTF_MID);
                if ($urandom_range(0, 1))
                    text_q.push_back(t_byte'($urandom_range(0, 255)));
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: text_q.push_back(CH_CR);
                    1: text_q.push_back(CH_LF);
                    default: begin
                        text_q.push_back(CH_CR);
                        text_q.push_back(CH_LF);
                    end
                endcase
            end
            default: begin
                push_letters($urandom_range(1, 6));
                text_q.push_back(CH_SP);
            end
        endcase
    endtask

    // Sends one word; holds it until accepted, then maybe opens a gap.
    task automatic send_byte(input t_byte b, input logic last);
        @(negedge clk);
        byte_valid <= 1'b1;
        text_byte  <= b;
        last_byte  <= last;
        do
            @(posedge clk);
        while (byte_stall);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                @(negedge clk);
                byte_valid <= 1'b0;
                repeat ($urandom_range(0, gap_max)) @(negedge clk);
            end
        end
    endtask

    // Streams end on a cut: the last fragment is often left unfinished.
    task automatic send_stream(input int len);
        if (len > 0) begin
            text_q.delete();
            while (text_q.size() < len)
                add_fragment();
            while (text_q.size() > len)
                void'(text_q.pop_back());
        end
        foreach (text_q[k])
            send_byte(text_q[k], k == text_q.size() - 1);
        streams_sent++;
    endtask

    // Waits for every predicted word, then lets a flush in flight finish.
    task automatic drain();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers change only with the block empty; both are written every time.
    task automatic start_phase(input logic [CFG_W-1:0] style, input logic ext,
                               input logic calm);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_STYLE;
        cfg_data  <= style;
        @(negedge clk);
        cfg_index <= CFG_EXTENSION_MODE;
        cfg_data  <= CFG_W'({3'($urandom_range(0, 7)), ext});
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
        if (calm) begin
            gap_max    = 0;
            stall_pct  = 0;
            stall_span = 0;
        end else begin
            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 6;
                default: gap_max = 15;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            stall_span = $urandom_range(0, 8);
        end
        burst_left = $urandom_range(1, 12);
    endtask

    initial begin
        int phase;
        int random_start;
        int phase_start;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: byte extremes as one-word streams, then string, substitution,
        // curly close, embedded code and nested comments in one short stream
        start_phase(CFG_W'(0), 1'b0, 1'b1);
        text_q.delete();
        text_q.push_back(8'hFF);
        send_stream(0);
        text_q.delete();
        text_q.push_back(8'h00);
        send_stream(0);
        text_q.delete();
        push_text("\"a[b]");
        text_q.push_back(UTF_LEAD);
        text_q.push_back(UTF_MID);
        text_q.push_back(UTF_RQUOT);
        push_text("(-x-)[[]]\n");
        send_stream(0);

        // random phases: extremes of both registers first, then random settings
        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_BYTES) begin
            case (phase)
                0: start_phase(CFG_W'(0), 1'b1, 1'b1);
                1: start_phase(CFG_W'(12), 1'b1, 1'b0);
                2: start_phase(CFG_W'(15), 1'b0, 1'b0);
                3: start_phase(CFG_W'(13), 1'b1, 1'b0);
                default: start_phase($urandom_range(0, 1) ? CFG_W'(0)
                                                          : CFG_W'($urandom_range(0, 15)),
                                     1'($urandom_range(0, 1)), 1'b0);
            endcase
            phase++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_BYTES)
                send_stream($urandom_range(0, 5) == 0 ? $urandom_range(31, 60)
                                                      : $urandom_range(1, 30));
        end

        drain();
        $display("Covered %0d input bytes in %0d streams under %0d register settings.",
                 items_sent, streams_sent, settings_used);
        $display("Checked %0d classified bytes, %0d mismatches.", results_seen, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
